// ----- src/websocket_frame_unmasker_defines.svh -----
// assertion macros shared by the websocket frame unmasker modules
// no dependencies; included by the front, queue and back modules
`ifndef WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH
`define WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WSFU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define WSFU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/wsfu_pkg.sv -----
// types and constants for the websocket frame unmasker
// no dependencies; imported by every module of the block
package wsfu_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 2;

    // result status codes
    localparam logic [2:0] ST_DATA     = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NOTFIN   = 3'd2;
    localparam logic [2:0] ST_UNMASKED = 3'd3;
    localparam logic [2:0] ST_LEN64    = 3'd4;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXTHI = 3'd2,
        PH_EXTLO = 3'd3,
        PH_KEY   = 3'd4,
        PH_DATA  = 3'd5
    } phase_t;

    // one classified result on its way from front to back
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] raw_byte;
        logic [7:0] key_byte;
        logic       last;
    } item_t;

endpackage

// ----- src/wsfu_front.sv -----
// header parser: tracks the frame phase, collects length and key, classifies bytes
// depends on wsfu_pkg and websocket_frame_unmasker_defines.svh
`include "websocket_frame_unmasker_defines.svh"

module wsfu_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_in_byte,
    input  logic           fifo_full,
    output logic           push,
    output wsfu_pkg::item_t push_item
);
    import wsfu_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  key_idx_reg, key_idx_next;
    logic        halted_reg, halted_next;
    logic        fire;

    assign s_ready = halted_reg | ~fifo_full;
    assign fire    = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR0;
            remaining_reg <= '0;
            len_hi_reg    <= '0;
            mask_key_reg  <= '0;
            key_idx_reg   <= '0;
            halted_reg    <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            len_hi_reg    <= len_hi_next;
            mask_key_reg  <= mask_key_next;
            key_idx_reg   <= key_idx_next;
            halted_reg    <= halted_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        len_hi_next    = len_hi_reg;
        mask_key_next  = mask_key_reg;
        key_idx_next   = key_idx_reg;
        halted_next    = halted_reg;
        push           = 1'b0;
        push_item      = '{status: ST_DATA, raw_byte: 8'h00, key_byte: 8'h00, last: 1'b1};

        if (fire && !halted_reg) begin
            unique case (phase_reg)
                PH_HDR1: begin
                    if (!s_in_byte[7]) begin
                        push             = 1'b1;
                        push_item.status = ST_UNMASKED;
                        halted_next      = 1'b1;
                        phase_next       = PH_HDR0;
                    end else if (s_in_byte[6:0] == LEN_EXT64) begin
                        push             = 1'b1;
                        push_item.status = ST_LEN64;
                        halted_next      = 1'b1;
                        phase_next       = PH_HDR0;
                    end else if (s_in_byte[6:0] == LEN_EXT16) begin
                        phase_next = PH_EXTHI;
                    end else begin
                        remaining_next = {9'd0, s_in_byte[6:0]};
                        key_idx_next   = '0;
                        phase_next     = PH_KEY;
                    end
                end
                PH_EXTHI: begin
                    len_hi_next = s_in_byte;
                    phase_next  = PH_EXTLO;
                end
                PH_EXTLO: begin
                    remaining_next = {len_hi_reg, s_in_byte};
                    key_idx_next   = '0;
                    phase_next     = PH_KEY;
                end
                PH_KEY: begin
                    mask_key_next[{key_idx_reg, 3'b000} +: 8] = s_in_byte;
                    key_idx_next = key_idx_reg + 2'd1;
                    if (key_idx_reg == 2'd3) begin
                        if (remaining_reg == '0) begin
                            push             = 1'b1;
                            push_item.status = ST_EMPTY;
                            phase_next       = PH_HDR0;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    push               = 1'b1;
                    push_item.raw_byte = s_in_byte;
                    push_item.key_byte = mask_key_reg[{key_idx_reg, 3'b000} +: 8];
                    push_item.last     = (remaining_reg == 16'd1);
                    key_idx_next       = key_idx_reg + 2'd1;
                    remaining_next     = remaining_reg - 16'd1;
                    if (remaining_reg == 16'd1) begin
                        phase_next = PH_HDR0;
                    end
                end
                default: begin
                    // first header byte, also the unused phase codes
                    if (!s_in_byte[7]) begin
                        push             = 1'b1;
                        push_item.status = ST_NOTFIN;
                        halted_next      = 1'b1;
                        phase_next       = PH_HDR0;
                    end else begin
                        phase_next = PH_HDR1;
                    end
                end
            endcase
        end
    end

    `WSFU_ASSERT_NEXT(a_halt_sticks, aclk, aresetn, halted_reg, halted_reg, "halt released")
    `WSFU_ASSERT_NOW(a_status_is_last, aclk, aresetn, push && push_item.status != ST_DATA,
        push_item.last && push_item.raw_byte == 8'h00, "status result not marked last")
    `WSFU_ASSERT_NEXT(a_no_push_when_halted, aclk, aresetn, halted_reg, !push,
        "result produced while halted")

endmodule

// ----- src/wsfu_fifo.sv -----
// short register queue decoupling the parser from the output stage
// depends on wsfu_pkg and websocket_frame_unmasker_defines.svh
`include "websocket_frame_unmasker_defines.svh"

module wsfu_fifo #(
    parameter int unsigned Depth = wsfu_pkg::FIFO_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wsfu_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output wsfu_pkg::item_t head_item
);
    import wsfu_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    item_t            mem_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CntW'(Depth));
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `WSFU_ASSERT_NOW(a_no_overflow, aclk, aresetn, push, !full, "push into full queue")
    `WSFU_ASSERT_NOW(a_no_underflow, aclk, aresetn, pop, not_empty, "pop from empty queue")
    `WSFU_ASSERT_NEXT(a_count_hold, aclk, aresetn, push && pop, $stable(count_reg),
        "occupancy moved on simultaneous push and pop")

endmodule

// ----- src/wsfu_back.sv -----
// output stage: applies the key byte and holds the result for the receiver
// depends on wsfu_pkg and websocket_frame_unmasker_defines.svh
`include "websocket_frame_unmasker_defines.svh"

module wsfu_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            not_empty,
    input  wsfu_pkg::item_t head_item,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [2:0]      m_status,
    output logic [7:0]      m_payload_byte,
    output logic            m_last_of_frame
);
    import wsfu_pkg::*;

    logic       valid_reg, valid_next;
    logic [2:0] status_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // the output register reloads from the queue head whenever it is empty or being drained
    assign pop        = not_empty & (~valid_reg | m_ready);
    assign valid_next = pop | (valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg <= head_item.status;
            byte_reg   <= head_item.raw_byte ^ head_item.key_byte;
            last_reg   <= head_item.last;
        end
    end

    assign m_valid         = valid_reg;
    assign m_status        = status_reg;
    assign m_payload_byte  = byte_reg;
    assign m_last_of_frame = last_reg;

    `WSFU_ASSERT_NEXT(a_pop_loads, aclk, aresetn, pop, valid_reg, "popped transaction lost")
    `WSFU_ASSERT_NOW(a_status_shape, aclk, aresetn, valid_reg && status_reg != ST_DATA,
        last_reg && byte_reg == 8'h00, "status result with payload or without last")
    `WSFU_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, valid_reg && !m_ready,
        valid_reg && $stable(status_reg) && $stable(byte_reg), "stalled transaction changed")

endmodule

// ----- src/websocket_frame_unmasker.sv -----
// websocket frame unmasker: client frame byte stream in, unmasked payload bytes out
// usage notes
//   s_ channel: one raw byte of the client frame stream per transaction
//   m_ channel: one result per transaction, either a payload byte (status 0,
//   key applied) or a status word (empty frame, not final, unmasked, 64-bit
//   length) which always carries last_of_frame and a zero payload byte
//   header and key bytes give no result unless they end with a status word;
//   payload bytes give one each, passing through the queue and output register to m_
//   throughput: one byte per cycle, set by the header parser;
//   the queue (two entries by default) and the output register keep that rate with m_ready high
//   when the receiver stalls the queue fills and s_ready drops until it drains
//   after an error status every further byte is taken and dropped until reset
//   reset (aresetn low at a clock edge) returns to the first header byte
//   and empties the queue and output register
// depends on wsfu_pkg, wsfu_front, wsfu_fifo and wsfu_back

module websocket_frame_unmasker #(
    parameter int unsigned FifoDepth = wsfu_pkg::FIFO_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [7:0] m_payload_byte,
    output logic       m_last_of_frame
);
    import wsfu_pkg::*;

    item_t push_item;
    item_t head_item;
    logic  push;
    logic  pop;
    logic  fifo_full;
    logic  fifo_not_empty;

    wsfu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    wsfu_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (fifo_not_empty),
        .head_item (head_item)
    );

    wsfu_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .not_empty       (fifo_not_empty),
        .head_item       (head_item),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_payload_byte  (m_payload_byte),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule
